@@ rtl/pst_pkg.sv @@
// pst_pkg: shared widths, operation and status codes, control structs
// for the process slot table; no dependencies
package pst_pkg;

  localparam int OP_W        = 3;
  localparam int ID_W        = 6;
  localparam int WANT_W      = 2;
  localparam int ST_W        = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_RUN    = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd4;

  localparam logic [ST_W-1:0] ST_FREE  = 2'd0;
  localparam logic [ST_W-1:0] ST_READY = 2'd1;
  localparam logic [ST_W-1:0] ST_RUN   = 2'd2;
  localparam logic [ST_W-1:0] WANT_ANY = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load_in;
    logic match;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } sts_t;

endpackage

@@ rtl/pst_ctrl.sv @@
// pst_ctrl: sequencer for the process slot table
// drives pst_dp through cmd_t, reads sts_t; uses pst_pkg
module pst_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  pst_pkg::sts_t sts,
  output pst_pkg::cmd_t cmd
);
  import pst_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.load_in = 1'b0;
    cmd.match   = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!sts.out_stall) begin
          cmd.exec  = 1'b1;
          in_tready = 1'b1;
          if (in_tvalid) begin
            cmd.load_in = 1'b1;
            state_nxt   = S_MATCH;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/pst_dp.sv @@
// pst_dp: slot status registers, match vectors, lowest-set-bit pick
// and result register; controlled by pst_ctrl, uses pst_pkg
module pst_dp #(
  parameter int SLOT_COUNT = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pst_pkg::cmd_t             cmd,
  output pst_pkg::sts_t             sts,
  input  logic [pst_pkg::OP_W-1:0]  in_op,
  input  logic [pst_pkg::ID_W-1:0]  in_id,
  input  logic [pst_pkg::WANT_W-1:0] in_want,
  input  logic                      out_tready,
  output logic                      out_tvalid,
  output logic [pst_pkg::ID_W-1:0]  out_fid,
  output logic                      out_ok,
  output logic [pst_pkg::ST_W-1:0]  out_st
);
  import pst_pkg::*;

  localparam int N   = SLOT_COUNT;
  localparam int IDW = $clog2(N + 1);
  localparam int SW  = $clog2(N);
  localparam int CW  = (IDW > ID_W) ? IDW : ID_W;
  localparam int VW  = 2 * N;
  localparam int JW  = $clog2(VW);

  logic [OP_W-1:0]   op_r;
  logic [ID_W-1:0]   id_r;
  logic [WANT_W-1:0] want_r;
  logic [ST_W-1:0]   slot_r [N];
  logic [IDW-1:0]    last_r;
  logic [VW-1:0]     w_r, run_r;
  logic [VW-1:0]     w_nxt, run_nxt;
  logic [ST_W-1:0]   addr_st_r;
  logic              out_valid_r;
  logic [ID_W-1:0]   out_fid_r;
  logic              out_ok_r;
  logic [ST_W-1:0]   out_st_r;

  logic [CW-1:0]     id_ext, last_ext, start;
  logic              id_valid;
  logic [ST_W-1:0]   want_eff;
  logic [SW-1:0]     addr_idx;

  logic [VW-1:0]     iso;
  logic              hit, run_hit;
  logic [JW-1:0]     j;
  logic [SW-1:0]     found_idx;
  logic [IDW-1:0]    found_id;

  logic              wr_en;
  logic [SW-1:0]     wr_idx;
  logic [ST_W-1:0]   wr_val;
  logic              last_en;
  logic [IDW-1:0]    res_fid;
  logic              res_ok;
  logic [ST_W-1:0]   res_st;

  // match vectors: lower half holds ids after the start, upper half wraps
  always_comb begin
    logic m, hi;
    id_ext   = CW'(id_r);
    last_ext = CW'(last_r);
    id_valid = (id_ext != '0) && (id_ext <= CW'(N));
    if (op_r == OP_CREATE) begin
      start    = ((last_ext == '0) || (last_ext > CW'(N))) ? CW'(1) : last_ext;
      want_eff = ST_FREE;
    end else begin
      start    = id_ext;
      want_eff = want_r;
    end
    addr_idx = id_valid ? SW'(id_ext - CW'(1)) : '0;
    for (int i = 0; i < N; i++) begin
      m  = (want_eff == WANT_ANY) ? (slot_r[i] != ST_FREE) : (slot_r[i] == want_eff);
      hi = (CW'(i) >= start);
      w_nxt[i]       = m & hi;
      w_nxt[N+i]     = m & ~hi;
      run_nxt[i]     = (slot_r[i] == ST_RUN) & hi;
      run_nxt[N+i]   = (slot_r[i] == ST_RUN) & ~hi;
    end
  end

  // lowest set bit of the match vector is the next slot in search order
  always_comb begin
    iso     = w_r & (~w_r + VW'(1));
    hit     = |w_r;
    run_hit = |(iso & run_r);
    j       = '0;
    for (int k = 0; k < VW; k++) begin
      if (iso[k]) begin
        j = j | JW'(k);
      end
    end
    found_idx = (j >= JW'(N)) ? SW'(j - JW'(N)) : SW'(j);
    found_id  = IDW'(found_idx) + IDW'(1);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = addr_idx;
    wr_val  = addr_st_r;
    last_en = 1'b0;
    res_fid = '0;
    res_ok  = 1'b0;
    res_st  = ST_FREE;
    unique case (op_r)
      OP_CREATE: begin
        if (hit) begin
          wr_en   = 1'b1;
          wr_idx  = found_idx;
          wr_val  = ST_READY;
          last_en = 1'b1;
          res_fid = found_id;
          res_ok  = 1'b1;
          res_st  = ST_READY;
        end
      end
      OP_RUN, OP_STOP, OP_DELETE: begin
        if (id_valid) begin
          wr_idx  = SW'(id_ext - CW'(1));
          res_fid = IDW'(id_ext);
          res_st  = addr_st_r;
          if (op_r == OP_RUN && addr_st_r == ST_READY) begin
            wr_en  = 1'b1;
            wr_val = ST_RUN;
            res_ok = 1'b1;
            res_st = ST_RUN;
          end else if (op_r == OP_STOP && addr_st_r == ST_RUN) begin
            wr_en  = 1'b1;
            wr_val = ST_READY;
            res_ok = 1'b1;
            res_st = ST_READY;
          end else if (op_r == OP_DELETE) begin
            wr_en  = 1'b1;
            wr_val = ST_FREE;
            res_ok = 1'b1;
            res_st = ST_FREE;
          end
        end
      end
      OP_FIND: begin
        if (id_valid && hit) begin
          res_fid = found_id;
          res_ok  = 1'b1;
          if (want_r == WANT_ANY) begin
            res_st = run_hit ? ST_RUN : ST_READY;
          end else begin
            res_st = want_r;
          end
        end
      end
      default: begin
        res_fid = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        slot_r[i] <= (i == 0) ? ST_RUN : ST_FREE;
      end
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec && wr_en) begin
        slot_r[wr_idx] <= wr_val;
      end
      if (cmd.exec && last_en) begin
        last_r <= found_id;
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_op;
      id_r   <= in_id;
      want_r <= in_want;
    end
    if (cmd.match) begin
      w_r       <= w_nxt;
      run_r     <= run_nxt;
      addr_st_r <= slot_r[addr_idx];
    end
    if (cmd.exec) begin
      out_fid_r <= ID_W'(res_fid);
      out_ok_r  <= res_ok;
      out_st_r  <= res_st;
    end
  end

  assign sts.out_stall = out_valid_r & ~out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_fid       = out_fid_r;
  assign out_ok        = out_ok_r;
  assign out_st        = out_st_r;

endmodule

@@ rtl/process_slot_table.sv @@
// process_slot_table: top level, streaming ports around pst_ctrl and pst_dp
// uses pst_pkg
//
//   channel  dir  handshake              tdata fields (low bit up)
//   in_      in   in_tvalid/in_tready    operation[2:0] slot_id[8:3] wanted_status[10:9]
//   out_     out  out_tvalid/out_tready  found_id[5:0] ok[6] slot_status[8:7]
//
// each word passes a match state that registers the rotated match vector, then an
// exec state for the lowest-set-bit pick, the slot update and loading the result register
// a new word is taken in the exec state unless the output stalls, as the last one finishes
// reset: slot 1 running, all others free, last allocated slot cleared
// a result held by out_tready still lets one word in; the pick cycle then waits
module process_slot_table #(
  parameter int SLOT_COUNT = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // operation, slot_id, wanted_status, zero fill
  input  logic [pst_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // found_id, ok, slot_status, zero fill
  output logic [pst_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import pst_pkg::*;

  cmd_t            cmd;
  sts_t            sts;
  logic [ID_W-1:0] fid;
  logic            ok;
  logic [ST_W-1:0] st;

  pst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pst_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tdata[OP_W-1:0]),
    .in_id      (in_tdata[OP_W+ID_W-1:OP_W]),
    .in_want    (in_tdata[OP_W+ID_W+WANT_W-1:OP_W+ID_W]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_fid    (fid),
    .out_ok     (ok),
    .out_st     (st)
  );

  assign out_tdata = {{(OUT_TDATA_W-ID_W-1-ST_W){1'b0}}, st, ok, fid};

endmodule

@@ tb/sv/process_slot_table_tb.sv @@
// process_slot_table_tb: stream-driven self-checking bench for the slot table,
// predicts each result word from an internal slot model and compares it field by field
// depends on pst_pkg and process_slot_table
module process_slot_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pst_pkg::*;

  localparam int SLOTS      = 32;
  localparam int HALF_CLK   = 6;
  localparam int RST_CYCLES = 12;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_LEN   = 400;
  localparam int HOLD_AT    = 300;
  localparam int BLOCKS     = 21;
  localparam int BLOCK_LEN  = 49;

  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_MIXED, MIX_NOISE} mix_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [WANT_W-1:0] want;
  } request_t;

  typedef struct packed {
    logic [ID_W-1:0] found_id;
    logic            ok;
    logic [ST_W-1:0] status;
  } reply_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  request_t        request_queue[$];
  reply_t          expected_replies[$];
  logic [ST_W-1:0] slot_model[1:SLOTS];
  int              last_slot;
  int              errors      = 0;
  int              words_sent  = 0;
  int              words_seen  = 0;
  int              send_gap    = 0;
  int              recv_gap    = 0;
  int              hold_left   = 0;
  bit              hold_done   = 0;
  int              idle_cycles = 0;

  process_slot_table #(.SLOT_COUNT(SLOTS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #(HALF_CLK) clk = ~clk;

  initial begin
    for (int i = 1; i <= SLOTS; i++) slot_model[i] = ST_FREE;
    slot_model[1] = ST_RUN;
    last_slot = 0;
  end

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // round-robin search from the slot after start, wrapping back to start itself
  function automatic int seek_slot(int start, logic [WANT_W-1:0] want);
    int sid;
    bit hit;
    sid = start;
    for (int n = 0; n < SLOTS; n++) begin
      sid = (sid >= SLOTS) ? 1 : sid + 1;
      hit = (want == WANT_ANY) ? (slot_model[sid] != ST_FREE) : (slot_model[sid] == want);
      if (hit) return sid;
    end
    return 0;
  endfunction

  function automatic reply_t apply_request(request_t r);
    reply_t rep;
    bit     valid;
    int     hit;
    int     start;
    rep   = '0;
    valid = (r.id >= 1) && (r.id <= SLOTS);
    case (r.op)
      OP_CREATE: begin
        start = (last_slot == 0 || last_slot > SLOTS) ? 1 : last_slot;
        hit = seek_slot(start, ST_FREE);
        if (hit != 0) begin
          slot_model[hit] = ST_READY;
          last_slot       = hit;
          rep.found_id    = hit[ID_W-1:0];
          rep.ok          = 1'b1;
          rep.status      = ST_READY;
        end
      end
      OP_RUN, OP_STOP, OP_DELETE: begin
        if (valid) begin
          if (r.op == OP_RUN && slot_model[r.id] == ST_READY) begin
            slot_model[r.id] = ST_RUN;
            rep.ok = 1'b1;
          end else if (r.op == OP_STOP && slot_model[r.id] == ST_RUN) begin
            slot_model[r.id] = ST_READY;
            rep.ok = 1'b1;
          end else if (r.op == OP_DELETE) begin
            slot_model[r.id] = ST_FREE;
            rep.ok = 1'b1;
          end
          rep.found_id = r.id;
          rep.status   = slot_model[r.id];
        end
      end
      OP_FIND: begin
        if (valid) begin
          hit = seek_slot(r.id, r.want);
          if (hit != 0) begin
            rep.found_id = hit[ID_W-1:0];
            rep.ok       = 1'b1;
            rep.status   = slot_model[hit];
          end
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  task automatic add_request(logic [OP_W-1:0] op, int id, int want);
    request_t r;
    r.op   = op;
    r.id   = id[ID_W-1:0];
    r.want = want[WANT_W-1:0];
    request_queue.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_replies.push_back(apply_request(request_queue.pop_front()));
        words_sent++;
        send_gap = pick_gap((words_sent / 80) % 5 == 2);
      end
      if (in_tvalid && !in_tready) begin
        in_tvalid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (request_queue.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {5'b0, request_queue[0].want, request_queue[0].id, request_queue[0].op};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    reply_t exp_rep;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        words_seen++;
        if (expected_replies.size() == 0) begin
          $error("result word with no request outstanding: %h", out_tdata);
          errors++;
        end else begin
          exp_rep = expected_replies.pop_front();
          if (out_tdata[5:0] !== exp_rep.found_id) begin
            $error("found_id: expected %0d, actual %0d", exp_rep.found_id, out_tdata[5:0]);
            errors++;
          end
          if (out_tdata[6] !== exp_rep.ok) begin
            $error("ok: expected %0d, actual %0d", exp_rep.ok, out_tdata[6]);
            errors++;
          end
          if (out_tdata[8:7] !== exp_rep.status) begin
            $error("slot_status: expected %0d, actual %0d", exp_rep.status, out_tdata[8:7]);
            errors++;
          end
        end
        recv_gap = pick_gap((words_seen / 80) % 5 == 4);
      end
      if (!hold_done && words_seen >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("process_slot_table verification failed");
        $finish;
      end
    end
  end

  initial begin
    mix_t mix;
    int   r;
    logic [OP_W-1:0] op;
    int   id;

    // directed words
    add_request(OP_CREATE, 0, 0);
    add_request(OP_CREATE, 5, 3);
    add_request(OP_RUN, 2, 0);
    add_request(OP_RUN, 2, 0);
    add_request(OP_STOP, 2, 0);
    add_request(OP_STOP, 3, 0);
    add_request(OP_DELETE, 3, 0);
    add_request(OP_DELETE, 3, 0);
    add_request(OP_RUN, 0, 0);
    add_request(OP_STOP, SLOTS + 1, 0);
    add_request(OP_DELETE, 63, 3);
    add_request(OP_FIND, SLOTS, WANT_ANY);
    add_request(OP_FIND, 1, ST_READY);
    add_request(OP_FIND, 2, ST_RUN);
    add_request(OP_FIND, 1, ST_RUN);
    add_request(OP_FIND, 5, ST_FREE);
    add_request(OP_FIND, 0, WANT_ANY);
    add_request(OP_FIND, 40, ST_READY);
    add_request(OP_RSVD5, 1, 0);
    add_request(OP_RSVD6, 2, 1);
    add_request(OP_RSVD7, 63, 3);
    add_request(OP_CREATE, 0, 0);
    add_request(OP_DELETE, 1, 0);
    add_request(OP_FIND, 7, ST_RUN);
    add_request(OP_RUN, SLOTS, 0);

    // random blocks: fill phases drive the table full, drain phases empty it
    for (int b = 0; b < BLOCKS; b++) begin
      mix = (b % 4 == 0) ? MIX_FILL : mix_t'($urandom_range(0, 3));
      for (int k = 0; k < BLOCK_LEN; k++) begin
        r = $urandom_range(0, 9);
        case (mix)
          MIX_FILL:  op = (r < 8) ? OP_CREATE : OP_W'($urandom_range(OP_RUN, OP_FIND));
          MIX_DRAIN: op = (r < 6) ? OP_DELETE : OP_W'($urandom_range(OP_CREATE, OP_FIND));
          MIX_MIXED: op = OP_W'($urandom_range(OP_CREATE, OP_FIND));
          default:   op = OP_W'($urandom_range(0, 7));
        endcase
        if (mix == MIX_NOISE || $urandom_range(0, 19) == 0) id = $urandom_range(0, 63);
        else id = $urandom_range(1, SLOTS);
        add_request(op, id, $urandom_range(0, 3));
      end
    end

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (request_queue.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_replies.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("process_slot_table verification clean");
    end else begin
      $display("process_slot_table verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pst_pkg.sv
rtl/pst_ctrl.sv
rtl/pst_dp.sv
rtl/process_slot_table.sv
tb/sv/process_slot_table_tb.sv
